>>> design/assert_macros.svh
// Assertion macros shared by the printer modules.
// Depends on nothing; modules include it before their declaration.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tsp_pkg.sv
// Types and constants of the text stream tilemap printer.
// Used by the front queue, the back engine and the top level.
package tsp_pkg;

  localparam int ADDR_W = 10;

  // Stream codes.
  localparam logic [7:0] CODE_FIRST_CTRL = 8'hEE;
  localparam logic [7:0] CODE_END        = 8'hFF;
  localparam logic [7:0] CODE_NOP        = 8'hFB;
  localparam logic [7:0] CODE_POS        = 8'hFE;
  localparam logic [7:0] CODE_CENTRE     = 8'hFC;
  localparam logic [7:0] CODE_ATTR       = 8'hF9;
  localparam logic [7:0] CODE_OBJ        = 8'hEF;
  localparam logic [7:0] CHAR_QUOTE      = 8'h60;
  localparam logic [7:0] CHAR_QUOTE_MAP  = 8'h5F;
  localparam logic [7:0] CHAR_HIGH       = 8'h8C;
  localparam logic [7:0] CHAR_HIGH_MAP   = 8'h3F;

  // Tile constants.
  localparam logic [15:0] BANK_NORMAL   = 16'h2000;
  localparam logic [15:0] BANK_SPECIAL  = 16'h6000;
  localparam logic [15:0] SMALL_BASE    = 16'h009F;
  localparam logic [15:0] SMALL_LOWER   = 16'h003C;
  localparam logic [15:0] BIG_LOWER     = 16'h0050;
  localparam logic [15:0] BIG_LOWER_R   = 16'h0051;
  localparam logic [15:0] TILE_SP_A     = 16'h00A4;
  localparam logic [15:0] TILE_SP_B     = 16'h00DA;
  localparam logic [6:0]  SMALL_SP_A    = 7'h64;
  localparam logic [6:0]  SMALL_SP_B    = 7'h65;
  localparam logic [7:0]  CENTRE_BUDGET = 8'd33;

  // Result kinds.
  localparam logic [1:0] KIND_TILE  = 2'd0;
  localparam logic [1:0] KIND_OBJ   = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [7:0] table_index;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] map_address;
    logic [15:0]       map_word;
    logic [2:0]        object_number;
    logic [15:0]       object_position;
    logic              last;
  } result_t;

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic       is_load;
    logic [7:0] data_byte;
    logic [7:0] table_index;
  } job_t;

  typedef enum logic [6:0] {
    PH_TEXT = 7'b0000001,
    PH_COL  = 7'b0000010,
    PH_ROW  = 7'b0000100,
    PH_CROW = 7'b0001000,
    PH_ATTR = 7'b0010000,
    PH_OBJ  = 7'b0100000,
    PH_SCAN = 7'b1000000
  } phase_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FEED = 6'b000010,
    ST_TILE = 6'b000100,
    ST_MRD  = 6'b001000,
    ST_MACC = 6'b010000,
    ST_FIN  = 6'b100000
  } eng_state_t;

  // Text byte remap ahead of the glyph lookup.
  function automatic logic [7:0] remap(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b == CHAR_QUOTE) c = CHAR_QUOTE_MAP;
    else if (b >= CHAR_HIGH) c = CHAR_HIGH_MAP;
    return c;
  endfunction

endpackage

>>> design/text_stream_tilemap_printer.sv
// One request at a time in the engine: a table load writes the glyph table, and a glyph
// byte reads the glyph table and emits two tile results if small, four if big.
// A centring terminator first measures the buffered bytes (one glyph memory read each)
// before the buffered bytes are replayed.
// Reset (rst, synchronous) clears parsing state and queues; the glyph table is not cleared.
module text_stream_tilemap_printer import tsp_pkg::*; #(
  parameter int SCAN_DEPTH = 15
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic job_valid;
  logic job_pop;
  job_t job;

  tsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  tsp_back #(.SCAN_DEPTH(SCAN_DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_pop     (job_pop),
    .job         (job),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

>>> design/tsp_ram.sv
// Generic single write port RAM with a registered read port.
// Depends on nothing.
module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> design/tsp_front.sv
// Front part: accepts requests, classifies them and queues them for the engine.
// Depends on tsp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tsp_front import tsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  job_valid,
  input  logic  job_pop,
  output job_t  job
);

  job_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign item_ready = (count != 2'd2);
  assign job_valid  = (count != 2'd0);
  assign job        = q[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = job_pop && job_valid;

  // Classified entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].is_load     <= item.func;
      q[wr_ptr].data_byte   <= item.data_byte;
      q[wr_ptr].table_index <= item.table_index;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `TSP_ASSERT_ALWAYS(a_count_bound, rst || (count != 2'd3), "queue count beyond depth")
  `TSP_ASSERT(a_ptr_match, (count != 2'd1) |-> (wr_ptr == rd_ptr), "queue pointers apart")

endmodule

>>> design/tsp_back.sv
// Back part: parses the stream, measures and replays centred text, emits results.
// Depends on tsp_pkg, tsp_ram and assert_macros.svh.
`include "assert_macros.svh"
module tsp_back import tsp_pkg::*; #(
  parameter int SCAN_DEPTH = 15
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_pop,
  input  job_t    job,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int CW = $clog2(SCAN_DEPTH + 2);
  localparam int IW = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(SCAN_DEPTH);

  eng_state_t state, state_next;
  phase_t     phase, phase_next;
  logic [15:0] cursor, cursor_next;
  logic [15:0] attr, attr_next;
  logic [7:0]  pend_col, pend_col_next;
  logic [7:0]  crow, crow_next;
  logic [7:0]  sbuf [SCAN_DEPTH];
  logic [CW-1:0] scnt, scnt_next;
  logic        sarg, sarg_next;
  logic [7:0]  cur_b, cur_b_next;
  logic        replay, replay_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] len, len_next;
  logic [7:0]  term_b, term_b_next;
  logic [CW-1:0] mi, mi_next;
  logic [CW-1:0] mend, mend_next;
  logic [7:0]  budget, budget_next;
  logic        m_replay, m_replay_next;
  logic [1:0]  tcnt, tcnt_next;
  logic        hold_v;
  result_t     hold;
  logic        out_v;
  result_t     out_r;
  logic        out_load;

  logic        can_emit, em_fire, flush, sb_we, adv, fin;
  result_t     em;
  logic        ram_we, ram_re;
  logic [7:0]  ram_waddr, ram_raddr, ram_wdata, ram_rdata;

  // Tile datapath signals.
  logic [6:0]  g_idx;
  logic [15:0] g_base, g_word;
  logic [9:0]  g_offs;
  logic [1:0]  g_last;
  logic [15:0] g_inc;
  logic [7:0]  m_byte;
  logic [CW-1:0] pos_inc;

  tsp_ram #(.WIDTH(8), .DEPTH(256)) u_glyph (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign can_emit     = !hold_v || !out_v || result_ready;
  assign result_valid = out_v;
  assign result       = out_r;
  assign pos_inc      = pos + CW'(1);
  assign m_byte       = sbuf[mi[IW-1:0]];
  assign out_load     = (em_fire && hold_v) || flush;

  // Glyph tile word and offset for the current tile step.
  always_comb begin
    g_idx  = ram_rdata[6:0];
    g_base = '0;
    g_word = '0;
    g_offs = '0;
    g_last = 2'd1;
    g_inc  = 16'd1;
    if (ram_rdata[7]) begin
      if (g_idx == SMALL_SP_A) g_base = TILE_SP_A | attr | BANK_SPECIAL;
      else if (g_idx == SMALL_SP_B) g_base = TILE_SP_B | attr | BANK_NORMAL;
      else g_base = ({9'd0, g_idx} + SMALL_BASE) | attr | BANK_NORMAL;
      if (tcnt[0]) begin
        g_offs = 10'd32;
        g_word = (g_idx == SMALL_SP_B) ? g_base : g_base + SMALL_LOWER;
      end else begin
        g_word = g_base;
      end
    end else begin
      g_base = {7'd0, ram_rdata, 1'b0} | attr | BANK_NORMAL;
      g_last = 2'd3;
      g_inc  = 16'd2;
      case (tcnt)
        2'd0: begin
          g_offs = 10'd0;
          g_word = g_base;
        end
        2'd1: begin
          g_offs = 10'd1;
          g_word = g_base + 16'd1;
        end
        2'd2: begin
          g_offs = 10'd32;
          g_word = g_base + BIG_LOWER;
        end
        default: begin
          g_offs = 10'd33;
          g_word = g_base + BIG_LOWER_R;
        end
      endcase
    end
  end

  // Engine sequencing.
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    cursor_next   = cursor;
    attr_next     = attr;
    pend_col_next = pend_col;
    crow_next     = crow;
    scnt_next     = scnt;
    sarg_next     = sarg;
    cur_b_next    = cur_b;
    replay_next   = replay;
    pos_next      = pos;
    len_next      = len;
    term_b_next   = term_b;
    mi_next       = mi;
    mend_next     = mend;
    budget_next   = budget;
    m_replay_next = m_replay;
    tcnt_next     = tcnt;
    job_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = job.table_index;
    ram_wdata = job.data_byte;
    ram_re    = 1'b0;
    ram_raddr = remap(cur_b);
    em_fire   = 1'b0;
    em        = '0;
    sb_we     = 1'b0;
    adv       = 1'b0;
    fin       = 1'b0;
    flush     = 1'b0;

    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          if (job.is_load) begin
            ram_we = 1'b1;
          end else begin
            cur_b_next  = job.data_byte;
            replay_next = 1'b0;
            state_next  = ST_FEED;
          end
        end
      end

      ST_FEED: begin
        if (can_emit) begin
          case (phase)
            PH_COL: begin
              pend_col_next = cur_b;
              phase_next    = PH_ROW;
              adv           = 1'b1;
            end
            PH_ROW: begin
              cursor_next = {3'd0, cur_b, 5'd0} + {8'd0, pend_col};
              phase_next  = PH_TEXT;
              adv         = 1'b1;
            end
            PH_CROW: begin
              crow_next = cur_b;
              if (replay && pos != len) begin
                phase_next    = PH_TEXT;
                mi_next       = pos_inc;
                mend_next     = len;
                budget_next   = CENTRE_BUDGET;
                m_replay_next = 1'b0;
                state_next    = ST_MRD;
              end else begin
                scnt_next  = '0;
                sarg_next  = 1'b0;
                phase_next = PH_SCAN;
                adv        = 1'b1;
              end
            end
            PH_ATTR: begin
              attr_next  = {cur_b[5:0], 10'd0};
              phase_next = PH_TEXT;
              adv        = 1'b1;
            end
            PH_OBJ: begin
              em_fire            = 1'b1;
              em.kind            = KIND_OBJ;
              em.object_number   = cur_b[2:0];
              em.object_position = cursor;
              phase_next         = PH_TEXT;
              adv                = 1'b1;
            end
            PH_SCAN: begin
              if (!sarg && (cur_b == CODE_END || cur_b == CODE_NOP)) begin
                // Terminator: measure the buffered bytes, then replay them.
                phase_next    = PH_TEXT;
                len_next      = scnt;
                term_b_next   = cur_b;
                scnt_next     = '0;
                mi_next       = '0;
                mend_next     = scnt;
                budget_next   = CENTRE_BUDGET;
                m_replay_next = 1'b1;
                state_next    = ST_MRD;
              end else if (scnt >= DEPTH_C) begin
                em_fire     = 1'b1;
                em.kind     = KIND_ERROR;
                phase_next  = PH_TEXT;
                scnt_next   = '0;
                sarg_next   = 1'b0;
                replay_next = 1'b0;
                fin         = 1'b1;
              end else begin
                sb_we     = 1'b1;
                scnt_next = scnt + CW'(1);
                sarg_next = sarg ? 1'b0 : (cur_b == CODE_OBJ);
                adv       = 1'b1;
              end
            end
            default: begin
              phase_next = PH_TEXT;
              if (cur_b < CODE_FIRST_CTRL) begin
                ram_re     = 1'b1;
                tcnt_next  = '0;
                state_next = ST_TILE;
              end else if (cur_b == CODE_END) begin
                em_fire = 1'b1;
                em.kind = KIND_END;
                adv     = 1'b1;
              end else if (cur_b == CODE_NOP) begin
                adv = 1'b1;
              end else if (cur_b == CODE_POS) begin
                phase_next = PH_COL;
                adv        = 1'b1;
              end else if (cur_b == CODE_CENTRE) begin
                phase_next = PH_CROW;
                adv        = 1'b1;
              end else if (cur_b == CODE_ATTR) begin
                phase_next = PH_ATTR;
                adv        = 1'b1;
              end else if (cur_b == CODE_OBJ) begin
                phase_next = PH_OBJ;
                adv        = 1'b1;
              end else begin
                em_fire     = 1'b1;
                em.kind     = KIND_ERROR;
                scnt_next   = '0;
                sarg_next   = 1'b0;
                replay_next = 1'b0;
                fin         = 1'b1;
              end
            end
          endcase
        end
      end

      ST_TILE: begin
        if (can_emit) begin
          em_fire        = 1'b1;
          em.kind        = KIND_TILE;
          em.map_address = cursor[ADDR_W-1:0] + g_offs;
          em.map_word    = g_word;
          if (tcnt == g_last) begin
            cursor_next = cursor + g_inc;
            adv         = 1'b1;
          end else begin
            tcnt_next = tcnt + 2'd1;
          end
        end
      end

      ST_MRD: begin
        ram_raddr = m_byte;
        if (mi >= mend || m_byte == CODE_END || m_byte == CODE_NOP) begin
          cursor_next = {3'd0, crow, 5'd0} + {9'd0, budget[7:1]};
          if (m_replay) begin
            replay_next = 1'b1;
            pos_next    = '0;
            cur_b_next  = (len != '0) ? sbuf[0] : term_b;
            state_next  = ST_FEED;
          end else begin
            adv = 1'b1;
          end
        end else if (m_byte == CODE_OBJ) begin
          mi_next = mi + CW'(2);
        end else begin
          ram_re     = 1'b1;
          state_next = ST_MACC;
        end
      end

      ST_MACC: begin
        budget_next = budget - (ram_rdata[7] ? 8'd1 : 8'd2);
        mi_next     = mi + CW'(1);
        state_next  = ST_MRD;
      end

      ST_FIN: begin
        if (!hold_v) begin
          state_next = ST_IDLE;
        end else if (!out_v || result_ready) begin
          flush      = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Step to the next replayed byte, or finish the request.
    if (adv) begin
      if (replay && pos != len) begin
        pos_next   = pos_inc;
        cur_b_next = (pos_inc < len) ? sbuf[pos_inc[IW-1:0]] : term_b;
        state_next = ST_FEED;
      end else begin
        fin = 1'b1;
      end
    end
    if (fin) state_next = ST_FIN;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_TEXT;
      cursor   <= '0;
      attr     <= '0;
      pend_col <= '0;
      crow     <= '0;
      scnt     <= '0;
      sarg     <= 1'b0;
      replay   <= 1'b0;
      pos      <= '0;
      len      <= '0;
      mi       <= '0;
      mend     <= '0;
      m_replay <= 1'b0;
      tcnt     <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      cursor   <= cursor_next;
      attr     <= attr_next;
      pend_col <= pend_col_next;
      crow     <= crow_next;
      scnt     <= scnt_next;
      sarg     <= sarg_next;
      replay   <= replay_next;
      pos      <= pos_next;
      len      <= len_next;
      mi       <= mi_next;
      mend     <= mend_next;
      m_replay <= m_replay_next;
      tcnt     <= tcnt_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_b  <= cur_b_next;
    term_b <= term_b_next;
    budget <= budget_next;
    if (sb_we) sbuf[scnt[IW-1:0]] <= cur_b;
  end

  // Hold stage keeps the newest result until it is known whether it is the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (out_load) out_v <= 1'b1;
      else if (result_ready) out_v <= 1'b0;
      if (em_fire) begin
        hold   <= em;
        hold_v <= 1'b1;
      end else if (flush) begin
        hold_v <= 1'b0;
      end
    end
  end

  // Output register; a flush marks the held result as the last of its request.
  always_ff @(posedge clk) begin
    if (out_load) out_r <= {hold[$bits(result_t)-1:1], flush};
  end

  `TSP_ASSERT(a_idle_no_hold, (state == ST_IDLE) |-> !hold_v, "result held while idle")
  `TSP_ASSERT(a_scan_bound, scnt <= DEPTH_C, "scan count beyond buffer depth")
  `TSP_ASSERT(a_replay_pos, replay |-> (pos <= len), "replay position past terminator")
  `TSP_ASSERT(a_emit_room, em_fire |-> can_emit, "result produced with no room")

endmodule
